[rtl/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg
// shared constants and a width helper for the ray and sphere intersection core
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  // sphere radius register, unsigned q8.8 mm
  localparam int unsigned RADIUS_W = 16;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd3072;

  // z coordinate reported on a miss, q15.8 mm (minus one mm)
  localparam int MISS_Z = -256;

  // low half width of a split operand
  function automatic int half_up(input int w);
    return (w + 1) / 2;
  endfunction

endpackage

`default_nettype wire

[rtl/rsi_wmul.sv]
// ----------------------------------------------------------------------------
// rsi_wmul
// two stage unsigned multiplier, operands split in halves into four products
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_wmul #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int AL  = rsi_pkg::half_up(A_W);
  localparam int AH  = A_W - AL;
  localparam int BL  = rsi_pkg::half_up(B_W);
  localparam int BH  = B_W - BL;
  localparam int P_W = A_W + B_W;

  logic [AL+BL-1:0] pp00_q;
  logic [AL+BH-1:0] pp01_q;
  logic [AH+BL-1:0] pp10_q;
  logic [AH+BH-1:0] pp11_q;
  logic [P_W-1:0]   p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= a_i[AL-1:0] * b_i[BL-1:0];
      pp01_q <= a_i[AL-1:0] * b_i[B_W-1:BL];
      pp10_q <= a_i[A_W-1:AL] * b_i[BL-1:0];
      pp11_q <= a_i[A_W-1:AL] * b_i[B_W-1:BL];
      p_q    <= (P_W'(pp11_q) << (AL + BL)) + (P_W'(pp01_q) << BL)
              + (P_W'(pp10_q) << AL) + P_W'(pp00_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[rtl/rsi_div.sv]
// ----------------------------------------------------------------------------
// rsi_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div #(
  parameter int N_W = 32,
  parameter int D_W = 16
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic [N_W-1:0] quo_o
);

  // word holds remaining dividend bits on top, quotient bits shifting in below
  logic [N_W-1:0] word_q [N_W];
  logic [D_W-1:0] rem_q  [N_W];
  logic [D_W-1:0] den_q  [N_W];
  logic [N_W-1:0] word_d [N_W];
  logic [D_W-1:0] rem_d  [N_W];
  logic [D_W-1:0] den_s  [N_W];
  logic [N_W-1:0] word_s [N_W];
  logic [D_W-1:0] rem_s  [N_W];
  logic [D_W:0]   trial  [N_W];
  logic           ge     [N_W];

  always_comb begin
    for (int j = 0; j < N_W; j++) begin
      word_s[j] = (j == 0) ? num_i : word_q[(j == 0) ? 0 : j - 1];
      rem_s[j]  = (j == 0) ? '0 : rem_q[(j == 0) ? 0 : j - 1];
      den_s[j]  = (j == 0) ? den_i : den_q[(j == 0) ? 0 : j - 1];
      trial[j]  = {rem_s[j], word_s[j][N_W-1]};
      ge[j]     = trial[j] >= {1'b0, den_s[j]};
      rem_d[j]  = ge[j] ? D_W'(trial[j] - {1'b0, den_s[j]}) : trial[j][D_W-1:0];
      word_d[j] = {word_s[j][N_W-2:0], ge[j]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < N_W; j++) begin
        word_q[j] <= word_d[j];
        rem_q[j]  <= rem_d[j];
        den_q[j]  <= den_s[j];
      end
    end
  end

  assign quo_o = word_q[N_W-1];

endmodule

`default_nettype wire

[rtl/ray_sphere_intersection_core.sv]
// widths: SW = sqrt bits = ceil(PW/2), MW = DIR_WIDTH + NW quotient bits of the divider
// throughput: one item per cycle unless the output stalls, set by the bit-per-stage sqrt and divider pipelines
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset: asynchronous active low, clears all valid bits, radius returns to 12 mm
// ----------------------------------------------------------------------------
// ray_sphere_intersection_core
// fixed point ray and sphere intersection, nearer root, saturated hit point
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersection_core #(
  parameter int COORD_WIDTH = 24,
  parameter int DIR_WIDTH   = 16,
  localparam int IN_W  = ((6 * COORD_WIDTH + 3 * DIR_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, centre_x, centre_y, centre_z
  input  logic [IN_W-1:0]               s_axis_tdata_i,
  // result items
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // point_x, point_y, point_z
  output logic [OUT_W-1:0]              m_axis_tdata_o,
  // hit
  output logic [0:0]                    m_axis_tuser_o,
  // radius register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsi_pkg::RADIUS_W-1:0]  cfg_data_i
);

  // widths of the intermediate values
  localparam int CW  = COORD_WIDTH;
  localparam int DW  = DIR_WIDTH;
  localparam int LW  = CW + 1;                 // l = origin - centre
  localparam int AW  = 2 * DW;                 // a = d.d
  localparam int HW  = DW + LW + 2;            // h = d.l
  localparam int CPW = 2 * LW;                 // |c|
  localparam int CSW = 2 * LW + 1;             // c = l.l - r*r
  localparam int RRW = 2 * rsi_pkg::RADIUS_W;  // r*r
  localparam int PW  = ((2 * HW > AW + CPW) ? 2 * HW : AW + CPW) + 1; // q
  localparam int SW  = rsi_pkg::half_up(PW);   // sqrt(q)
  localparam int RW  = 2 * SW + 1;             // sqrt remainder
  localparam int NW  = ((HW > SW + 1) ? HW : SW + 1) + 1; // n = -h - sqrt(q)
  localparam int MW  = DW + NW;                // |d * n|
  localparam int FW  = MW + 2;                 // origin + step

  typedef struct packed {
    logic [2:0][CW-1:0] o;
    logic [2:0][DW-1:0] d;
    logic [AW-1:0]      a;
    logic [HW-1:0]      h;
    logic               miss;
  } pay_t;

  typedef struct packed {
    logic [2:0][CW-1:0] o;
    logic [AW-1:0]      a;
    logic [2:0]         neg;
    logic               miss;
  } dv_t;

  // global advance: the pipeline moves unless a result is held
  logic en;
  logic vout_q;
  assign en              = !vout_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // valid bits of the fixed stages
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v7_q, v8_q, v9_q;
  logic sq_v_q [SW+1];
  logic dv_v_q [MW];

  // radius register, written only while the first stage is empty
  // (an item waiting there still needs the old radius for r*r)
  logic [rsi_pkg::RADIUS_W-1:0] radius_q;
  assign cfg_ready_o = !v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rsi_pkg::RADIUS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  // ---------------- stage 1: unpack, l = origin - centre ----------------
  logic [2:0][CW-1:0] in_o, in_c;
  logic [2:0][DW-1:0] in_d;
  logic [2:0][CW-1:0] o1_q;
  logic [2:0][DW-1:0] d1_q;
  logic signed [LW-1:0] l1_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_o[k] = s_axis_tdata_i[k*CW +: CW];
      in_d[k] = s_axis_tdata_i[3*CW + k*DW +: DW];
      in_c[k] = s_axis_tdata_i[3*CW + 3*DW + k*CW +: CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o1_q <= in_o;
      d1_q <= in_d;
      for (int k = 0; k < 3; k++) begin
        l1_q[k] <= LW'($signed(in_o[k])) - LW'($signed(in_c[k]));
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [DW+LW-1:0] dl2_q [3];
  logic signed [2*LW-1:0]  ll2_q [3];
  logic signed [2*DW-1:0]  dd2_q [3];
  logic [RRW-1:0]          rr2_q;
  logic [2:0][CW-1:0]      o2_q;
  logic [2:0][DW-1:0]      d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dl2_q[k] <= $signed(d1_q[k]) * l1_q[k];
        ll2_q[k] <= l1_q[k] * l1_q[k];
        dd2_q[k] <= $signed(d1_q[k]) * $signed(d1_q[k]);
      end
      rr2_q <= radius_q * radius_q;
      o2_q  <= o1_q;
      d2_q  <= d1_q;
    end
  end

  // ---------------- stage 3: a, h, c ----------------
  logic [AW-1:0]         a3_q;
  logic signed [HW-1:0]  h3_q;
  logic signed [CSW-1:0] c3_q;
  logic [2:0][CW-1:0]    o3_q;
  logic [2:0][DW-1:0]    d3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= AW'($unsigned(dd2_q[0])) + AW'($unsigned(dd2_q[1]))
            + AW'($unsigned(dd2_q[2]));
      h3_q <= HW'(dl2_q[0]) + HW'(dl2_q[1]) + HW'(dl2_q[2]);
      c3_q <= CSW'(ll2_q[0]) + CSW'(ll2_q[1]) + CSW'(ll2_q[2])
            - $signed(CSW'(rr2_q));
      o3_q <= o2_q;
      d3_q <= d2_q;
    end
  end

  // ---------------- stages 4-5: h*h and a*|c| ----------------
  logic [HW-1:0]     h_mag;
  logic [CPW-1:0]    c_mag;
  logic [2*HW-1:0]   hsq;
  logic [AW+CPW-1:0] ac;
  pay_t              pay4_q, pay5_q;
  logic              cneg4_q, cneg5_q;

  assign h_mag = h3_q[HW-1] ? HW'(-h3_q) : HW'(h3_q);
  assign c_mag = c3_q[CSW-1] ? CPW'(-c3_q) : CPW'(c3_q);

  rsi_wmul #(.A_W(HW), .B_W(HW)) u_hsq (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (h_mag),
    .b_i   (h_mag),
    .p_o   (hsq)
  );

  rsi_wmul #(.A_W(AW), .B_W(CPW)) u_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (a3_q),
    .b_i   (c_mag),
    .p_o   (ac)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay4_q.o    <= o3_q;
      pay4_q.d    <= d3_q;
      pay4_q.a    <= a3_q;
      pay4_q.h    <= h3_q;
      pay4_q.miss <= 1'b0;
      cneg4_q     <= c3_q[CSW-1];
      pay5_q      <= pay4_q;
      cneg5_q     <= cneg4_q;
    end
  end

  // ---------------- stage 6 and sqrt: q = h*h - a*c, one root bit a stage ----------------
  logic [PW:0]    q_sum, q_diff;
  logic [PW-1:0]  q_val;
  logic           q_miss;
  pay_t           pay6;
  logic [RW-1:0]  sq_rem_q  [SW+1];
  logic [SW-1:0]  sq_root_q [SW+1];
  pay_t           sq_pay_q  [SW+1];
  logic [RW-1:0]  sq_rem_d  [SW];
  logic [SW-1:0]  sq_root_d [SW];
  logic [RW-1:0]  sq_trial  [SW];

  assign q_sum  = (PW+1)'(hsq) + (PW+1)'(ac);
  assign q_diff = (PW+1)'(hsq) - (PW+1)'(ac);
  assign q_val  = cneg5_q ? q_sum[PW-1:0] : q_diff[PW-1:0];
  // miss on a negative discriminant or a zero direction
  assign q_miss = (pay5_q.a == '0) || (!cneg5_q && q_diff[PW]);

  always_comb begin
    pay6      = pay5_q;
    pay6.miss = q_miss;
  end

  always_comb begin
    for (int j = 0; j < SW; j++) begin
      // (2r + 2^i) * 2^i with i = SW-1-j
      sq_trial[j]  = ((RW'(sq_root_q[j]) << 1) | (RW'(1) << (SW - 1 - j))) << (SW - 1 - j);
      sq_rem_d[j]  = sq_rem_q[j];
      sq_root_d[j] = sq_root_q[j];
      if (sq_rem_q[j] >= sq_trial[j]) begin
        sq_rem_d[j]  = sq_rem_q[j] - sq_trial[j];
        sq_root_d[j] = sq_root_q[j] | (SW'(1) << (SW - 1 - j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= RW'(q_val);
      sq_root_q[0] <= '0;
      sq_pay_q[0]  <= pay6;
      for (int j = 0; j < SW; j++) begin
        sq_rem_q[j+1]  <= sq_rem_d[j];
        sq_root_q[j+1] <= sq_root_d[j];
        sq_pay_q[j+1]  <= sq_pay_q[j];
      end
    end
  end

  // ---------------- stage 7: n = -h - sqrt(q) ----------------
  logic [NW-1:0] n7_q;
  pay_t          pay7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n7_q   <= NW'(-NW'($signed(sq_pay_q[SW].h))) - NW'(sq_root_q[SW]);
      pay7_q <= sq_pay_q[SW];
    end
  end

  // ---------------- stages 8-9: |d * n| per axis ----------------
  logic [NW-1:0]      n_mag;
  logic [DW-1:0]      d_mag [3];
  logic [MW-1:0]      prod  [3];
  logic [MW-1:0]      quo   [3];
  dv_t                dv7, dv8_q, dv9_q;
  dv_t                dvp_q [MW];

  assign n_mag = n7_q[NW-1] ? NW'(-n7_q) : n7_q;

  always_comb begin
    dv7.o    = pay7_q.o;
    dv7.a    = pay7_q.a;
    dv7.miss = pay7_q.miss;
    for (int k = 0; k < 3; k++) begin
      d_mag[k]  = pay7_q.d[k][DW-1] ? DW'(-pay7_q.d[k]) : pay7_q.d[k];
      dv7.neg[k] = pay7_q.d[k][DW-1] ^ n7_q[NW-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rsi_wmul #(.A_W(DW), .B_W(NW)) u_dn (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (d_mag[k]),
      .b_i   (n_mag),
      .p_o   (prod[k])
    );

    // quotient truncated toward zero: magnitude divide, sign applied after
    rsi_div #(.N_W(MW), .D_W(AW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (prod[k]),
      .den_i (dv9_q.a),
      .quo_o (quo[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv8_q    <= dv7;
      dv9_q    <= dv8_q;
      dvp_q[0] <= dv9_q;
      for (int j = 1; j < MW; j++) begin
        dvp_q[j] <= dvp_q[j-1];
      end
    end
  end

  // ---------------- output stage: origin + step, saturate ----------------
  localparam logic [FW-1:0] SAT_HI = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [FW-1:0] SAT_LO = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [FW-1:0] step [3];
  logic signed [FW-1:0] psum [3];
  logic [2:0][CW-1:0]   pt_d;
  logic [2:0][CW-1:0]   pt_q;
  logic                 hit_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      step[k] = dvp_q[MW-1].neg[k] ? -$signed(FW'(quo[k])) : $signed(FW'(quo[k]));
      psum[k] = FW'($signed(dvp_q[MW-1].o[k])) + step[k];
      if (psum[k] > $signed(SAT_HI)) begin
        pt_d[k] = SAT_HI[CW-1:0];
      end else if (psum[k] < $signed(SAT_LO)) begin
        pt_d[k] = SAT_LO[CW-1:0];
      end else begin
        pt_d[k] = psum[k][CW-1:0];
      end
    end
    if (dvp_q[MW-1].miss) begin
      pt_d[0] = '0;
      pt_d[1] = '0;
      pt_d[2] = CW'(rsi_pkg::MISS_Z);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q  <= pt_d;
      hit_q <= !dvp_q[MW-1].miss;
    end
  end

  // valid chain, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      vout_q <= 1'b0;
      for (int j = 0; j <= SW; j++) sq_v_q[j] <= 1'b0;
      for (int j = 0; j < MW; j++)  dv_v_q[j] <= 1'b0;
    end else if (en) begin
      v1_q      <= s_axis_tvalid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      sq_v_q[0] <= v5_q;
      for (int j = 0; j < SW; j++) sq_v_q[j+1] <= sq_v_q[j];
      v7_q      <= sq_v_q[SW];
      v8_q      <= v7_q;
      v9_q      <= v8_q;
      dv_v_q[0] <= v9_q;
      for (int j = 1; j < MW; j++) dv_v_q[j] <= dv_v_q[j-1];
      vout_q    <= dv_v_q[MW-1];
    end
  end

  assign m_axis_tvalid_o   = vout_q;
  assign m_axis_tdata_o    = OUT_W'(pt_q);
  assign m_axis_tuser_o[0] = hit_q;

  // an accepted item always occupies the first stage
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted item missing from first stage");

  // a held result freezes the valid chain, sampled at stages 3, 7 and 9 and the output
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(v3_q) && $stable(v9_q) && $stable(v7_q) && vout_q))
    else $error("pipeline moved while output stalled");

  // a miss always reports the fixed point
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |->
      (pt_q[0] == '0 && pt_q[1] == '0 && pt_q[2] == CW'(rsi_pkg::MISS_Z)))
    else $error("miss result with wrong point");

endmodule

`default_nettype wire

[dv/tb_ray_sphere_intersection_core.sv]
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersection_core
// self-checking bench: directed, aimed and random rays through the intersection core,
// an exact integer predictor of the hit point, and several radius settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic signed [23:0] org [3];
  logic signed [15:0] dir [3];
  logic signed [23:0] cen [3];
} ray_query_t;

typedef struct {
  logic signed [23:0] pt [3];
  logic               hit;
} hit_point_t;

class hit_point_board;
  hit_point_t         pending [$];
  logic        [15:0] radius;
  int                 errors;
  int                 hits;
  int                 misses;

  function new();
    radius = rsi_pkg::RADIUS_RESET;
    errors = 0;
    hits   = 0;
    misses = 0;
  endfunction

  // exact nearer root of |O + tD - C| = r, point saturated to the coordinate range
  function hit_point_t predict(ray_query_t rq);
    logic signed [127:0] d [3];
    logic signed [127:0] l [3];
    logic signed [127:0] a, h, c, q, rt, tr, n, num, v;
    hit_point_t          res;
    a = 0;
    h = 0;
    c = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = $signed(rq.dir[k]);
      l[k] = $signed(rq.org[k]) - $signed(rq.cen[k]);
      a += d[k] * d[k];
      h += d[k] * l[k];
      c += l[k] * l[k];
    end
    c -= $signed({112'd0, radius}) * $signed({112'd0, radius});
    q = h * h - a * c;
    if (q < 0 || a == 0) begin
      res.pt[0] = '0;
      res.pt[1] = '0;
      res.pt[2] = 24'(rsi_pkg::MISS_Z);
      res.hit   = 1'b0;
      return res;
    end
    // bit by bit integer square root, rounded down
    rt = 0;
    for (int i = 63; i >= 0; i--) begin
      tr = rt | (128'sd1 <<< i);
      if (tr * tr <= q) rt = tr;
    end
    n = -h - rt;
    for (int k = 0; k < 3; k++) begin
      num = d[k] * n;
      v   = $signed(rq.org[k]) + num / a;  // signed divide truncates toward zero
      if (v > 128'sd8388607) v = 128'sd8388607;
      if (v < -128'sd8388608) v = -128'sd8388608;
      res.pt[k] = v[23:0];
    end
    res.hit = 1'b1;
    return res;
  endfunction

  function void note_query(ray_query_t rq);
    pending = {pending, predict(rq)};
  endfunction

  function void check_point(logic [71:0] data, logic hit);
    hit_point_t exp_pt;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result item pt=%h hit=%b", $time, data, hit);
      errors++;
      return;
    end
    exp_pt = pending.pop_front();
    if (exp_pt.hit) hits++;
    else misses++;
    for (int k = 0; k < 3; k++)
      if (data[24*k +: 24] !== exp_pt.pt[k]) begin
        $display("%0t: point[%0d] expected %0d actual %0d", $time, k,
                 exp_pt.pt[k], $signed(data[24*k +: 24]));
        errors++;
      end
    if (hit !== exp_pt.hit) begin
      $display("%0t: hit expected %b actual %b", $time, exp_pt.hit, hit);
      errors++;
    end
  endfunction
endclass

module tb_ray_sphere_intersection_core;

  localparam int LATENCY   = 116;
  localparam int MAX_CYCLE = 1000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [191:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [71:0]  m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  hit_point_board board = new();
  int  cycles = 0;
  int  sent = 0;
  int  radius_count = 0;
  bit  quiet = 1'b0;       // no idling on either side
  bit  hold_req = 1'b0;    // ask the receiver for a long hold-off

  always #5 clk_i = ~clk_i;

  ray_sphere_intersection_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("ray_sphere_intersection_core verification failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (quiet || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  // receiver: random stalls, plus one long hold-off counted here
  initial begin : result_ready
    int stall;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i = 1'b0;
        repeat (500) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = gap_len();
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // result item accepted at the rising edge
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_point(m_axis_tdata_o, m_axis_tuser_o[0]);

  // one input item, valid held across back to back items
  task automatic send_query(ray_query_t rq);
    int idle;
    idle = gap_len();
    if (idle > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {rq.cen[2], rq.cen[1], rq.cen[0], rq.dir[2], rq.dir[1], rq.dir[0],
                       rq.org[2], rq.org[1], rq.org[0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_query(rq);
    sent++;
    @(negedge clk_i);
  endtask

  // drain all results, then let the pipeline settle before touching the register
  task automatic drain();
    s_axis_tvalid_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic write_radius(logic [15:0] value);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.radius = value;
    radius_count++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic ray_query_t make_query(int ox, int oy, int oz, int dx, int dy, int dz,
                                            int cx, int cy, int cz);
    ray_query_t rq;
    rq.org[0] = 24'(ox); rq.org[1] = 24'(oy); rq.org[2] = 24'(oz);
    rq.dir[0] = 16'(dx); rq.dir[1] = 16'(dy); rq.dir[2] = 16'(dz);
    rq.cen[0] = 24'(cx); rq.cen[1] = 24'(cy); rq.cen[2] = 24'(cz);
    return rq;
  endfunction

  // ray from near the sphere aimed at its centre, with some jitter
  function automatic ray_query_t aimed_query();
    ray_query_t rq;
    longint     l [3];
    longint     m, span, scale;
    span  = (board.radius * 4) + 512;
    m     = 0;
    scale = $urandom_range(32767, 1);
    for (int k = 0; k < 3; k++) begin
      rq.cen[k] = 24'(int'($urandom_range(40000)) - 20000);
      rq.org[k] = 24'(longint'(rq.cen[k]) + longint'($urandom_range(int'(2 * span))) - span);
      l[k] = longint'(rq.cen[k]) - longint'(rq.org[k]) + int'($urandom_range(64)) - 32;
      if (l[k] > m) m = l[k];
      if (-l[k] > m) m = -l[k];
    end
    // a fraction point away so the root lies behind the origin
    if ($urandom_range(9) == 0) scale = -scale;
    for (int k = 0; k < 3; k++)
      rq.dir[k] = (m == 0) ? 16'(int'($urandom)) : 16'(l[k] * scale / m);
    return rq;
  endfunction

  function automatic ray_query_t random_query();
    ray_query_t rq;
    int         p;
    p = $urandom_range(99);
    if (p < 60) return aimed_query();
    for (int k = 0; k < 3; k++) begin
      rq.org[k] = 24'($urandom);
      rq.dir[k] = 16'($urandom);
      rq.cen[k] = 24'($urandom);
      if (p < 80) begin  // small coordinates, random direction
        rq.org[k] = 24'(int'($urandom_range(8192)) - 4096);
        rq.cen[k] = 24'(int'($urandom_range(8192)) - 4096);
      end
    end
    if (p >= 95) for (int k = 0; k < 3; k++) rq.dir[k] = '0;
    return rq;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_query(random_query());
  endtask

  initial begin : stimulus
    logic [15:0] radii [5];
    radii = '{16'd0, 16'd65535, 16'd256, 16'd1, 16'd1000};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rays at the reset radius of 12 mm
    quiet = 1'b1;
    send_query(make_query(0, 0, -10240, 0, 0, 16384, 0, 0, 0));          // head-on hit
    send_query(make_query(5000, 0, -10240, 0, 0, 16384, 0, 0, 0));       // miss
    send_query(make_query(3072, 0, -10240, 0, 0, 16384, 0, 0, 0));       // tangent
    send_query(make_query(100, 200, 300, 0, 0, 0, 0, 0, 0));             // zero direction
    send_query(make_query(0, 0, 0, 11585, 11585, 0, 0, 0, 0));           // origin at centre
    send_query(make_query(0, 0, 10240, 0, 0, 16384, 0, 0, 0));           // sphere behind
    send_query(make_query(8388600, 0, 0, -16384, 0, 0, 8388600, 0, 0));  // saturate high
    send_query(make_query(-8388600, 0, 0, 16384, 0, 0, -8388600, 0, 0)); // saturate low
    send_query(make_query(8388607, 8388607, 8388607, 32767, 32767, 32767,
                          8388607, 8388607, 8388607));
    send_query(make_query(-8388608, -8388608, -8388608, -32768, -32768, -32768,
                          -8388608, -8388608, -8388608));
    send_query(make_query(-8388608, 0, 0, 32767, 0, 0, 8388607, 0, 0));
    send_query(make_query(0, -10240, 0, 0, 1, 0, 0, 0, 0));              // tiny direction
    send_query(make_query(0, 0, -10240, 0, 0, -32768, 0, 0, 0));
    quiet = 1'b0;

    write_radius(rsi_pkg::RADIUS_RESET);
    hold_req = 1'b1;  // receiver holds off while the sender keeps offering
    random_phase(130);
    for (int r = 0; r < 5; r++) begin
      write_radius(radii[r]);
      quiet = (r == 2);
      random_phase(130);
    end
    quiet = 1'b0;
    write_radius(16'($urandom));
    random_phase(130);

    drain();
    $display("sent %0d rays over %0d radius settings: %0d hits, %0d misses",
             sent, radius_count, board.hits, board.misses);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ray_sphere_intersection_core verification clean");
    else
      $display("ray_sphere_intersection_core verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/rsi_pkg.sv
rtl/rsi_wmul.sv
rtl/rsi_div.sv
rtl/ray_sphere_intersection_core.sv
dv/tb_ray_sphere_intersection_core.sv
